// File: rtl/core/mfw_pkg.sv
// Shared types, constants and helpers of the median filter window unit.
package mfw_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int ROW_BITS = 12;
   localparam int COL_BITS = 12;
   localparam int BANK_BITS = 3;
   localparam int WIDTH_BITS = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 12;
   localparam int FRAME_WIDTH_BITS = 11;
   localparam int FRAME_HEIGHT_BITS = 12;
   localparam int FRAME_WIDTH_RESET = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [PIXEL_BITS-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic                  frame_last;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] eff_width;
      logic [ROW_BITS-1:0]   eff_height;
   } frame_type;

   typedef struct packed {
      logic                  wr_en;
      logic [BANK_BITS-1:0]  wr_bank;
      logic [COL_BITS-1:0]   wr_col;
      logic [PIXEL_BITS-1:0] pixel;
      logic                  emit;
      logic [ROW_BITS-1:0]   out_row;
      logic [COL_BITS-1:0]   out_col;
      logic [BANK_BITS-1:0]  out_bank;
      logic                  last;
   } entry_type;

   function automatic int mirror_index(input int i, input int n);
      int k;
      k = i;
      if (k < 0) k = -1 - k;
      if (k >= n) k = 2 * n - 1 - k;
      if (k < 0) k = 0;
      if (k >= n) k = n - 1;
      return k;
   endfunction

endpackage

// File: rtl/core/mfw_front.sv
// Front end: accepts requests, tracks frame positions and queues writes and outputs.
module mfw_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int WINDOW = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  mfw_pkg::req_type                       req_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mfw_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mfw_pkg::CSR_DATA_BITS-1:0]      csr_data,
   output mfw_pkg::frame_type                     frame,
   output logic                                   push,
   output mfw_pkg::entry_type                     push_entry,
   input  logic                                   q_full
);

   localparam int HALF = WINDOW / 2;
   localparam int ROWS = WINDOW + 1;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int BW = $clog2(ROWS);
   localparam int WB = mfw_pkg::WIDTH_BITS;
   localparam int RB = mfw_pkg::ROW_BITS;

   logic [mfw_pkg::FRAME_WIDTH_BITS-1:0]  fw_ff, fw_in;
   logic [mfw_pkg::FRAME_HEIGHT_BITS-1:0] fh_ff, fh_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RB-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [BW-1:0] in_bank_ff, in_bank_in, out_bank_ff, out_bank_in;
   logic [WB-1:0] eff_w;
   logic [RB-1:0] eff_h;
   logic accept, is_pixel, complete, due, do_write, do_emit, last;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      if (WB'(fw_ff) < WB'(3)) eff_w = WB'(3);
      else if (WB'(fw_ff) > WB'(MAX_WIDTH)) eff_w = WB'(MAX_WIDTH);
      else eff_w = WB'(fw_ff);
      eff_h = (fh_ff < RB'(3)) ? RB'(3) : fh_ff;
   end

   assign frame.eff_width = eff_w;
   assign frame.eff_height = eff_h;

   assign accept = req_valid && !q_full;
   assign is_pixel = req_data.opcode == mfw_pkg::OP_PIXEL;
   assign complete = in_row_ff >= eff_h;
   assign due = (in_row_ff > RB'(HALF)) || (in_row_ff == RB'(HALF) && in_col_ff >= CW'(HALF));
   assign do_write = accept && is_pixel && !complete;
   assign do_emit = accept && (is_pixel ? (!complete && due) : complete);
   assign last = (out_row_ff == eff_h - RB'(1)) && (WB'(out_col_ff) == eff_w - WB'(1));
   assign push = do_write || do_emit;

   always_comb begin
      push_entry = '0;
      push_entry.wr_en = do_write;
      push_entry.wr_bank = mfw_pkg::BANK_BITS'(in_bank_ff);
      push_entry.wr_col = mfw_pkg::COL_BITS'(in_col_ff);
      push_entry.pixel = req_data.pixel_in;
      push_entry.emit = do_emit;
      push_entry.out_row = out_row_ff;
      push_entry.out_col = mfw_pkg::COL_BITS'(out_col_ff);
      push_entry.out_bank = mfw_pkg::BANK_BITS'(out_bank_ff);
      push_entry.last = last;
   end

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_bank_in = in_bank_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_bank_in = out_bank_ff;
      if (csr_valid && (csr_index == mfw_pkg::CSR_FRAME_WIDTH ||
                        csr_index == mfw_pkg::CSR_FRAME_HEIGHT)) begin
         if (csr_index == mfw_pkg::CSR_FRAME_WIDTH) begin
            fw_in = csr_data[mfw_pkg::FRAME_WIDTH_BITS-1:0];
         end else begin
            fh_in = csr_data[mfw_pkg::FRAME_HEIGHT_BITS-1:0];
         end
         in_col_in = '0;
         in_row_in = '0;
         in_bank_in = '0;
         out_col_in = '0;
         out_row_in = '0;
         out_bank_in = '0;
      end else begin
         if (do_write) begin
            if (WB'(in_col_ff) + WB'(1) >= eff_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RB'(1);
               in_bank_in = (in_bank_ff == BW'(ROWS - 1)) ? '0 : in_bank_ff + BW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (do_emit) begin
            if (last) begin
               in_col_in = '0;
               in_row_in = '0;
               in_bank_in = '0;
               out_col_in = '0;
               out_row_in = '0;
               out_bank_in = '0;
            end else if (WB'(out_col_ff) + WB'(1) >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RB'(1);
               out_bank_in = (out_bank_ff == BW'(ROWS - 1)) ? '0 : out_bank_ff + BW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= mfw_pkg::FRAME_WIDTH_BITS'(mfw_pkg::FRAME_WIDTH_RESET);
         fh_ff <= mfw_pkg::FRAME_HEIGHT_BITS'(mfw_pkg::FRAME_HEIGHT_RESET);
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_bank_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_bank_ff <= '0;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         in_bank_ff <= in_bank_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_bank_ff <= out_bank_in;
      end
   end

endmodule

// File: rtl/core/mfw_queue.sv
// Short queue of line buffer writes and output jobs between front and back end.
module mfw_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mfw_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mfw_pkg::entry_type head_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   mfw_pkg::entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full = count_ff == NW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (pop) rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop) count_in = count_ff + NW'(1);
      else if (pop && !push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: rtl/core/mfw_back.sv
// Back end: line buffers, column fetch, reflected window and rank-based median.
module mfw_back #(
   parameter int MAX_WIDTH = 1024,
   parameter int WINDOW = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  mfw_pkg::frame_type frame,
   input  logic               q_valid,
   input  mfw_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mfw_pkg::rsp_type   rsp_data
);

   localparam int HALF = WINDOW / 2;
   localparam int ROWS = WINDOW + 1;
   localparam int TAPS = WINDOW * WINDOW;
   localparam int MID = TAPS / 2;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int BW = $clog2(ROWS);
   localparam int SW = $clog2(WINDOW);
   localparam int RW = $clog2(TAPS);
   localparam int LW = $clog2(HALF + 2);
   localparam int PB = mfw_pkg::PIXEL_BITS;

   logic [PB-1:0] mem_ff [ROWS][MAX_WIDTH];
   logic [PB-1:0] rd_ff [ROWS];

   logic en, finishing, op_fetch, op_emit;
   logic busy_ff, busy_in;
   logic [LW-1:0] left_ff, left_in, new_left;
   logic [CW-1:0] fcol_ff, fcol_in, new_col;
   mfw_pkg::entry_type tok_ff, tok_in;

   logic vb_ff, b_fetch_ff, b_emit_ff;
   mfw_pkg::entry_type b_tok_ff;
   logic [PB-1:0] sel_col [WINDOW];
   logic [PB-1:0] colbuf_ff [WINDOW][WINDOW];

   logic vc_ff;
   mfw_pkg::entry_type c_tok_ff;
   logic [PB-1:0] win_in [TAPS];

   logic vd_ff, d_last_ff;
   logic [PB-1:0] vals_d_ff [TAPS];
   logic [TAPS-1:0] lt_in [TAPS];

   logic ve_ff, e_last_ff;
   logic [PB-1:0] vals_e_ff [TAPS];
   logic [TAPS-1:0] lt_e_ff [TAPS];

   logic vf_ff, f_last_ff;
   logic [PB-1:0] vals_f_ff [TAPS];
   logic [RW-1:0] rank_f_ff [TAPS];
   logic [PB-1:0] med_in;

   logic rsp_valid_ff;
   mfw_pkg::rsp_type rsp_ff;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign finishing = busy_ff && (left_ff <= LW'(1));
   assign op_fetch = left_ff != '0;
   assign op_emit = left_ff <= LW'(1);
   assign q_pop = en && q_valid && (!busy_ff || finishing);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // The first output of a row loads the leading columns; later ones load one at most.
   always_comb begin
      int c, w, f, s;
      c = int'(q_entry.out_col);
      w = int'(frame.eff_width);
      if (c == 0) begin
         f = (w - 1 < HALF) ? w : HALF + 1;
         s = 0;
      end else if (c + HALF <= w - 1) begin
         f = 1;
         s = c + HALF;
      end else begin
         f = 0;
         s = 0;
      end
      new_left = LW'(f);
      new_col = CW'(s);
   end

   always_comb begin
      busy_in = busy_ff && !finishing;
      left_in = left_ff;
      fcol_in = fcol_ff;
      tok_in = tok_ff;
      if (busy_ff && op_fetch) begin
         left_in = left_ff - LW'(1);
         fcol_in = fcol_ff + CW'(1);
      end
      if (q_pop && q_entry.emit) begin
         busy_in = 1'b1;
         left_in = new_left;
         fcol_in = new_col;
         tok_in = q_entry;
      end
   end

   genvar gb;
   for (gb = 0; gb < ROWS; gb++) begin : g_bank
      always_ff @(posedge clock) begin
         if (q_pop && q_entry.wr_en && q_entry.wr_bank[BW-1:0] == BW'(gb)) begin
            mem_ff[gb][q_entry.wr_col[CW-1:0]] <= q_entry.pixel;
         end
         if (en) rd_ff[gb] <= mem_ff[gb][fcol_ff];
      end
   end

   always_comb begin
      int r, h, rr, bk;
      r = int'(b_tok_ff.out_row);
      h = int'(frame.eff_height);
      for (int dy = 0; dy < WINDOW; dy++) begin
         rr = mfw_pkg::mirror_index(r + dy - HALF, h);
         bk = int'(b_tok_ff.out_bank) + rr - r;
         if (bk < 0) bk = bk + ROWS;
         else if (bk >= ROWS) bk = bk - ROWS;
         sel_col[dy] = rd_ff[BW'(bk)];
      end
   end

   always_comb begin
      int c, w, n, cc, slot;
      c = int'(c_tok_ff.out_col);
      w = int'(frame.eff_width);
      n = (c + HALF < w - 1) ? c + HALF : w - 1;
      for (int dx = 0; dx < WINDOW; dx++) begin
         cc = mfw_pkg::mirror_index(c + dx - HALF, w);
         slot = n - cc;
         for (int dy = 0; dy < WINDOW; dy++) begin
            win_in[dy * WINDOW + dx] = colbuf_ff[SW'(slot)][dy];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            lt_in[i][j] = (vals_d_ff[j] < vals_d_ff[i]) ||
                          (vals_d_ff[j] == vals_d_ff[i] && j < i);
         end
      end
   end

   always_comb begin
      med_in = '0;
      for (int i = 0; i < TAPS; i++) begin
         if (rank_f_ff[i] == RW'(MID)) med_in = med_in | vals_f_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         busy_ff <= busy_in;
         vb_ff <= busy_ff;
         vc_ff <= vb_ff && b_emit_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         rsp_valid_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         left_ff <= left_in;
         fcol_ff <= fcol_in;
         tok_ff <= tok_in;
         b_fetch_ff <= op_fetch;
         b_emit_ff <= op_emit;
         b_tok_ff <= tok_ff;
         if (vb_ff && b_fetch_ff) begin
            colbuf_ff[0] <= sel_col;
            for (int k = 1; k < WINDOW; k++) colbuf_ff[k] <= colbuf_ff[k - 1];
         end
         c_tok_ff <= b_tok_ff;
         vals_d_ff <= win_in;
         d_last_ff <= c_tok_ff.last;
         vals_e_ff <= vals_d_ff;
         lt_e_ff <= lt_in;
         e_last_ff <= d_last_ff;
         vals_f_ff <= vals_e_ff;
         for (int i = 0; i < TAPS; i++) rank_f_ff[i] <= RW'($countones(lt_e_ff[i]));
         f_last_ff <= e_last_ff;
         rsp_ff.pixel_out <= med_in;
         rsp_ff.frame_last <= f_last_ff;
      end
   end

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> left_ff <= LW'(HALF + 1))
      else $error("fetch count out of range");

   a_job_taken: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_entry.emit |=> busy_ff)
      else $error("output job lost by sequencer");

   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      vf_ff && en |=> rsp_valid)
      else $error("median stage did not reach output");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vf_ff) && $stable(f_last_ff))
      else $error("pipeline moved while output stalled");

endmodule

// File: rtl/core/median_filter_window_unit.sv
// Top level of the streaming WINDOW x WINDOW median filter unit.
// Requests carry an opcode and a pixel: OP_PIXEL writes the next raster pixel,
// OP_DRAIN pushes out one pending output once the whole frame has been received.
// A request is taken when req_valid is high and req_stall is low; a response is
// taken when rsp_valid is high and rsp_stall is low. Each response is the median
// of the mirror-reflected window around one pixel; frame_last marks the final one.
// The csr port sets frame width (index 0) and height (index 1) and restarts the
// frame; it is always ready and should be written only while the unit is idle.
// Outputs lag inputs by WINDOW/2 rows plus WINDOW/2 pixels; once an output is due,
// it passes through the queue and then the fetch and median pipeline.
// Throughput is one pixel per cycle within a row unless a stall holds it; the
// first output of each row reads WINDOW/2 + 1 columns from the line buffer banks,
// which holds the back end at each row start; a short queue absorbs this.
// Reset restores 640 x 480 and clears all positions; line buffers are not cleared.
// While rsp_stall is high with a response pending, the whole back end holds, the
// queue fills, and then req_stall rises until the result is taken.
module median_filter_window_unit #(
   parameter int MAX_WIDTH = 1024,
   parameter int WINDOW = 5,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mfw_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mfw_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mfw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfw_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   mfw_pkg::frame_type frame;
   mfw_pkg::entry_type push_entry, head_entry;
   logic push, q_full, q_pop, head_valid;

   mfw_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .WINDOW(WINDOW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .frame(frame),
      .push(push),
      .push_entry(push_entry),
      .q_full(q_full)
   );

   mfw_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(q_full),
      .pop(q_pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   mfw_back #(
      .MAX_WIDTH(MAX_WIDTH),
      .WINDOW(WINDOW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .frame(frame),
      .q_valid(head_valid),
      .q_entry(head_entry),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

// File: dv/tb_median_filter_window_unit.sv
// Testbench for the median filter window unit with a scoreboard that predicts each median.
`timescale 1ns / 100ps

module tb_median_filter_window_unit;

   localparam int LINE_SLOTS = 1024;
   localparam int KEPT_ROWS = 6;
   localparam int SETTLE_CYCLES = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int PARTIAL_CAP = 60;

   class median_scoreboard;
      logic [mfw_pkg::PIXEL_BITS-1:0] line_mem [KEPT_ROWS*LINE_SLOTS];
      int width_reg = mfw_pkg::FRAME_WIDTH_RESET;
      int height_reg = mfw_pkg::FRAME_HEIGHT_RESET;
      int in_col, in_row, out_col, out_row;
      mfw_pkg::rsp_type expected_medians[$];
      int errors;
      int matched;

      function int cols();
         return (width_reg < 3) ? 3 : (width_reg > LINE_SLOTS) ? LINE_SLOTS : width_reg;
      endfunction

      function int rows();
         return (height_reg < 3) ? 3 : height_reg;
      endfunction

      function int reflect(int i, int n);
         int k;
         k = i;
         if (k < 0) k = -1 - k;
         if (k >= n) k = 2 * n - 1 - k;
         if (k < 0) k = 0;
         if (k >= n) k = n - 1;
         return k;
      endfunction

      function void write_reg(logic [mfw_pkg::CSR_INDEX_BITS-1:0] index,
                              logic [mfw_pkg::CSR_DATA_BITS-1:0] value);
         if (index == mfw_pkg::CSR_FRAME_WIDTH) begin
            width_reg = int'(value[mfw_pkg::FRAME_WIDTH_BITS-1:0]);
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end else if (index == mfw_pkg::CSR_FRAME_HEIGHT) begin
            height_reg = int'(value);
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
      endfunction

      function void predict_median(int w, int h);
         logic [mfw_pkg::PIXEL_BITS-1:0] taps [25];
         logic [mfw_pkg::PIXEL_BITS-1:0] v;
         mfw_pkg::rsp_type r;
         int n, j, rr;
         n = 0;
         for (int dy = -2; dy <= 2; dy++) begin
            rr = reflect(out_row + dy, h) % KEPT_ROWS;
            for (int dx = -2; dx <= 2; dx++) begin
               taps[n] = line_mem[rr*LINE_SLOTS + reflect(out_col + dx, w)];
               n++;
            end
         end
         for (int i = 1; i < 25; i++) begin
            v = taps[i];
            j = i - 1;
            while (j >= 0 && taps[j] > v) begin
               taps[j+1] = taps[j];
               j--;
            end
            taps[j+1] = v;
         end
         r.pixel_out = taps[12];
         r.frame_last = (out_row == h - 1) && (out_col == w - 1);
         expected_medians.insert(expected_medians.size(), r);
         if (r.frame_last) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col++;
         end
      endfunction

      function void note_request(mfw_pkg::req_type q);
         int w, h, p;
         bit complete;
         w = cols();
         h = rows();
         complete = in_row >= h;
         if (q.opcode == mfw_pkg::OP_PIXEL) begin
            if (complete) return;
            if (in_col >= w) in_col = w - 1;
            line_mem[(in_row % KEPT_ROWS)*LINE_SLOTS + in_col] = q.pixel_in;
            p = in_row * w + in_col;
            if (in_col + 1 >= w) begin
               in_col = 0;
               in_row++;
            end else begin
               in_col++;
            end
            if (p >= 2 * w + 2) predict_median(w, h);
         end else if (complete) begin
            predict_median(w, h);
         end
      endfunction

      function void check_median(mfw_pkg::rsp_type got);
         mfw_pkg::rsp_type e;
         if (expected_medians.size() == 0) begin
            $display("%0t: unexpected result pixel_out %0d frame_last %0d", $time,
                     got.pixel_out, got.frame_last);
            errors++;
            return;
         end
         e = expected_medians.pop_front();
         matched++;
         if (got.pixel_out !== e.pixel_out) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel_out, got.pixel_out);
            errors++;
         end
         if (got.frame_last !== e.frame_last) begin
            $display("%0t: frame_last expected %0d actual %0d", $time, e.frame_last,
                     got.frame_last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_medians.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   mfw_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   mfw_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [mfw_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mfw_pkg::CSR_DATA_BITS-1:0] csr_data;

   median_scoreboard board = new();
   int idle_cycles;
   int items_sent;

   median_filter_window_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (req_valid && !req_stall) board.note_request(req_data);
      if (rsp_valid && !rsp_stall) board.check_median(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_median_filter_window_unit failed");
         $finish;
      end
   end

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [mfw_pkg::PIXEL_BITS-1:0] any_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return mfw_pkg::PIXEL_BITS'($urandom_range(0, 255));
   endfunction

   initial begin
      bit long_hold_done;
      long_hold_done = 0;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (!long_hold_done && board.matched >= 50 && req_valid) begin
            long_hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap_length() + 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send(mfw_pkg::opcode_type op, logic [mfw_pkg::PIXEL_BITS-1:0] px);
      int g;
      req_valid <= 1'b1;
      req_data <= '{opcode: op, pixel_in: px};
      do @(posedge clock); while (req_stall);
      items_sent++;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [mfw_pkg::CSR_INDEX_BITS-1:0] index,
                            logic [mfw_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(index, value);
   endtask

   task automatic set_frame(logic [mfw_pkg::CSR_DATA_BITS-1:0] w,
                            logic [mfw_pkg::CSR_DATA_BITS-1:0] h);
      wait_idle();
      write_csr(mfw_pkg::CSR_FRAME_WIDTH, w);
      write_csr(mfw_pkg::CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // A well-formed frame is all its pixels followed by the drains for the last two rows
   // and two pixels; noise adds early drains, stray pixels and surplus drains.
   task automatic run_frame(bit noisy, bit partial);
      int w, h, total, cap;
      w = board.cols();
      h = board.rows();
      cap = (w * h - 1 < PARTIAL_CAP) ? w * h - 1 : PARTIAL_CAP;
      total = partial ? $urandom_range(1, cap) : w * h;
      for (int i = 0; i < total; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) send(mfw_pkg::OP_DRAIN, any_pixel());
         send(mfw_pkg::OP_PIXEL, any_pixel());
      end
      if (partial) return;
      if (noisy && $urandom_range(0, 1)) send(mfw_pkg::OP_PIXEL, any_pixel());
      for (int i = 0; i < 2 * w + 2; i++) send(mfw_pkg::OP_DRAIN, any_pixel());
      if (noisy && $urandom_range(0, 1)) send(mfw_pkg::OP_DRAIN, any_pixel());
   endtask

   initial begin
      int sent_before;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = mfw_pkg::CSR_FRAME_WIDTH;
      csr_data = '0;
      items_sent = 0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_frame(12'd0, 12'd1);
      send(mfw_pkg::OP_DRAIN, 8'hff);
      send(mfw_pkg::OP_PIXEL, 8'h00);
      send(mfw_pkg::OP_PIXEL, 8'hff);
      send(mfw_pkg::OP_PIXEL, 8'h00);
      send(mfw_pkg::OP_PIXEL, 8'hff);
      send(mfw_pkg::OP_PIXEL, 8'h80);
      send(mfw_pkg::OP_PIXEL, 8'h7f);
      send(mfw_pkg::OP_PIXEL, 8'hff);
      send(mfw_pkg::OP_PIXEL, 8'hff);
      send(mfw_pkg::OP_DRAIN, 8'h55);
      send(mfw_pkg::OP_PIXEL, 8'haa);
      send(mfw_pkg::OP_PIXEL, 8'h01);
      for (int i = 0; i < 7; i++) send(mfw_pkg::OP_DRAIN, 8'haa);
      send(mfw_pkg::OP_DRAIN, 8'h00);
      send(mfw_pkg::OP_DRAIN, 8'h00);

      set_frame(12'hfff, 12'd3);
      run_frame(1'b1, 1'b1);
      set_frame(12'd1024, 12'd2);
      run_frame(1'b0, 1'b1);
      set_frame(12'd3, 12'd4095);
      run_frame(1'b0, 1'b1);

      sent_before = items_sent;
      while (items_sent - sent_before < 850) begin
         if ($urandom_range(0, 5) == 0)
            set_frame(12'($urandom_range(0, 2)), 12'($urandom_range(0, 4)));
         else
            set_frame(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)));
         repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 3) == 0, 1'b0);
         if ($urandom_range(0, 4) == 0) run_frame(1'b1, 1'b1);
      end

      wait_idle();
      if (board.errors == 0 && board.pending() == 0)
         $display("tb_median_filter_window_unit passed");
      else
         $display("tb_median_filter_window_unit failed");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/mfw_pkg.sv
rtl/core/mfw_front.sv
rtl/core/mfw_queue.sv
rtl/core/mfw_back.sv
rtl/core/median_filter_window_unit.sv
dv/tb_median_filter_window_unit.sv
